/* hdl/trailing_moving_average_warmup_defines.svh */
// ----------------------------------------------------------------------------
// Trailing moving average assertion macros
// Shared property forms for the checker; clock and reset are the block ports.
// ----------------------------------------------------------------------------
`ifndef TRAILING_MOVING_AVERAGE_WARMUP_DEFINES_SVH
`define TRAILING_MOVING_AVERAGE_WARMUP_DEFINES_SVH

// same-cycle implication
`define TMAW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMAW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tmaw_pkg.sv */
// ----------------------------------------------------------------------------
// tmaw_pkg
// Shared widths, reset constant and status type of the moving average block.
// ----------------------------------------------------------------------------
package tmaw_pkg;

   localparam int DATA_W = 32;
   localparam int DAYS_W = 4;

   localparam logic [DAYS_W-1:0] DAYS_RESET = 4'd7;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* hdl/tmaw_history.sv */
// ----------------------------------------------------------------------------
// tmaw_history
// Sample delay line: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmaw_history #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                        clock,
   input  logic                        write_en,
   input  logic [ADDR_W-1:0]           write_addr,
   input  logic [tmaw_pkg::DATA_W-1:0] write_data,
   input  logic                        read_en,
   input  logic [ADDR_W-1:0]           read_addr,
   output logic [tmaw_pkg::DATA_W-1:0] read_data
);

   logic [tmaw_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [tmaw_pkg::DATA_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* hdl/tmaw_divider.sv */
// ----------------------------------------------------------------------------
// tmaw_divider
// Bit-serial restoring divider: one quotient bit per cycle, result held.
// ----------------------------------------------------------------------------
module tmaw_divider #(
   parameter int SUM_W   = 42,
   parameter int COUNT_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   input  logic [COUNT_W-1:0]          divisor,
   output logic [tmaw_pkg::DATA_W-1:0] quotient,
   output tmaw_pkg::div_status_type    status
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] divisor_ff;
   logic [ITER_W-1:0]  iter_ff;
   logic               busy_ff, done_ff;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;

   always_comb begin
      trial = {rem_ff, shift_ff[SUM_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      if (!diff[COUNT_W]) begin
         rem_in   = diff[COUNT_W-1:0];
         shift_in = {shift_ff[SUM_W-2:0], 1'b1};
      end else begin
         rem_in   = trial[COUNT_W-1:0];
         shift_in = {shift_ff[SUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         iter_ff <= ITER_W'(SUM_W);
      end else if (busy_ff) begin
         iter_ff <= iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff   <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
   end

   assign quotient    = shift_ff[tmaw_pkg::DATA_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* hdl/trailing_moving_average_warmup.sv */
// ----------------------------------------------------------------------------
// trailing_moving_average_warmup
// Trailing boxcar mean of Q24.8 samples over window_days * STEPS_PER_DAY
// samples, averaging all samples so far during warm-up.
//
//   channel  direction  ports                                  accepted when
//   req      in         req_sample, req_first                  req_valid & req_ready
//   rsp      out        rsp_average, rsp_window_full           rsp_valid & rsp_ready
//   csr      in         csr_write_data                         csr_write_enable
//
// Each item passes through the read, update, start and divide states; the
// divide state waits on the bit-serial divider that makes one quotient bit a cycle.
// Items are worked one at a time; req_ready is high only between items.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and its result waits in the divider until the output is taken.
// Reset (synchronous) restores 7 days and restarts warm-up; no clearing pass.
// ----------------------------------------------------------------------------
module trailing_moving_average_warmup #(
   parameter int STEPS_PER_DAY = 96,
   parameter int MAX_WINDOW    = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tmaw_pkg::DATA_W-1:0] req_sample,
   input  logic                        req_first,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tmaw_pkg::DATA_W-1:0] rsp_average,
   output logic                        rsp_window_full,
   input  logic                        csr_write_enable,
   input  logic [tmaw_pkg::DAYS_W-1:0] csr_write_data
);

   localparam int SLOT_W  = $clog2(MAX_WINDOW);
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = tmaw_pkg::DATA_W + SLOT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE
   } state_type;

   function automatic logic [COUNT_W-1:0] window_length(
      input logic [tmaw_pkg::DAYS_W-1:0] days
   );
      int unsigned d;
      int unsigned prod;
      d = (days == '0) ? 1 : int'(days);
      prod = d * STEPS_PER_DAY;
      if (prod > MAX_WINDOW) begin
         prod = MAX_WINDOW;
      end
      return COUNT_W'(prod);
   endfunction

   state_type                   state_ff;
   logic [COUNT_W-1:0]          window_ff;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic                        full_ff;
   logic                        rsp_valid_ff;
   logic [tmaw_pkg::DATA_W-1:0] rsp_average_ff;
   logic                        rsp_window_full_ff;
   logic [tmaw_pkg::DATA_W-1:0] sample_ff;
   logic [tmaw_pkg::DATA_W-1:0] old_sample;
   logic [tmaw_pkg::DATA_W-1:0] quotient;
   logic [SLOT_W:0]             slot_inc;
   logic                        was_full;
   logic                        out_free;
   logic                        div_start;
   logic                        req_take;
   tmaw_pkg::div_status_type    div_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = (state_ff == ST_START);

   always_comb begin
      was_full = (count_ff == window_ff);
      count_in = was_full ? count_ff : count_ff + 1'b1;
      sum_in   = sum_ff - (was_full ? SUM_W'(old_sample) : '0) + SUM_W'(sample_ff);
      slot_inc = (SLOT_W + 1)'(slot_ff) + 1'b1;
      slot_in  = (slot_inc >= (SLOT_W + 1)'(window_ff)) ? '0 : slot_inc[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= window_length(tmaw_pkg::DAYS_RESET);
         sum_ff       <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            window_ff <= window_length(csr_write_data);
            sum_ff    <= '0;
            count_ff  <= '0;
            slot_ff   <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff  <= ST_READ;
                  sample_ff <= req_sample;
                  if (req_first) begin
                     sum_ff   <= '0;
                     count_ff <= '0;
                     slot_ff  <= '0;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
               slot_ff  <= slot_in;
               full_ff  <= (count_in == window_ff);
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_status.done && out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_average_ff     <= quotient;
                  rsp_window_full_ff <= full_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   tmaw_history #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (SLOT_W)
   ) u_history (
      .clock      (clock),
      .write_en   (state_ff == ST_UPDATE),
      .write_addr (slot_ff),
      .write_data (sample_ff),
      .read_en    (state_ff == ST_READ),
      .read_addr  (slot_ff),
      .read_data  (old_sample)
   );

   tmaw_divider #(
      .SUM_W   (SUM_W),
      .COUNT_W (COUNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_window_full = rsp_window_full_ff;

endmodule

/* hdl/tmaw_checker.sv */
// ----------------------------------------------------------------------------
// tmaw_checker
// Port-level checks of the moving average block, bound to the top level.
// ----------------------------------------------------------------------------
`include "trailing_moving_average_warmup_defines.svh"

module tmaw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [tmaw_pkg::DATA_W-1:0] req_sample,
   input logic                        req_first,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tmaw_pkg::DATA_W-1:0] rsp_average,
   input logic                        rsp_window_full,
   input logic                        csr_write_enable,
   input logic [tmaw_pkg::DAYS_W-1:0] csr_write_data
);

   `TMAW_ASSERT_NEXT(rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")
   `TMAW_ASSERT_NEXT(rsp_payload_holds, rsp_valid && !rsp_ready, $stable(rsp_average) && $stable(rsp_window_full), "rsp payload changed while stalled")
   `TMAW_ASSERT_NEXT(busy_after_accept, req_valid && req_ready, !req_ready, "second item taken while busy")
   `TMAW_ASSERT_NEXT(no_early_result, req_valid && req_ready && (!rsp_valid || rsp_ready), !rsp_valid, "result appeared too early")
   `TMAW_ASSERT_NOW(result_ends_work, $rose(rsp_valid), $past(!req_ready), "result without item in work")

endmodule

bind trailing_moving_average_warmup tmaw_checker u_checker (.*);
